### hw/rtl/srcc_pkg.sv
// shared types, constants and codes for the sorted region coverage check
// no dependencies
package srcc_pkg;

    localparam int MAX_REGIONS = 64;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int ADDR_W      = 64;
    localparam int PAGES_W     = 52;
    localparam int PAGE_SHIFT  = 12;
    localparam int REM_W       = PAGES_W + 1;
    localparam int APB_ADDR_W  = 2;
    localparam int APB_DATA_W  = 32;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam int REG_CHECK_ENABLED = 0;

    typedef struct packed {
        logic [1:0]         command;
        logic [ADDR_W-1:0]  entry_start;
        logic [PAGES_W-1:0] entry_pages;
        logic [ADDR_W-1:0]  range_start;
        logic [ADDR_W-1:0]  range_length;
    } t_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] stop_address;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
    } t_region;

    typedef struct packed {
        logic       latch;
        logic       idx_from_count;
        logic       clear_count;
        logic       rd_en;
        logic       rd_prev;
        logic       wr_shift;
        logic       wr_new;
        logic       q_init;
        logic       q_last;
        logic       q_span;
        logic       q_take;
        logic       q_upd;
        logic       idx_inc;
        logic       finish;
        logic [1:0] fin_status;
        logic       fin_cursor;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic idx_zero;
        logic idx_at_count;
        logic base_gt;
        logic len_zero;
        logic rem_zero;
        logic below;
        logic covered;
    } t_dp_sts;

endpackage

### hw/rtl/srcc_dp.sv
// datapath: region table memory, insert shifting and coverage walk arithmetic
// depends on srcc_pkg
module srcc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srcc_pkg::t_item    i_item,
    input  srcc_pkg::t_dp_cmd  i_cmd,
    output srcc_pkg::t_dp_sts  o_sts,
    output logic               o_result_valid,
    output srcc_pkg::t_result  o_result
);

    srcc_pkg::t_region r_mem [srcc_pkg::MAX_REGIONS];
    srcc_pkg::t_region r_rd;

    logic [srcc_pkg::CNT_W-1:0]   r_count;
    logic [srcc_pkg::CNT_W-1:0]   r_idx;
    logic [srcc_pkg::ADDR_W-1:0]  r_entry_start;
    logic [srcc_pkg::PAGES_W-1:0] r_entry_pages;
    logic [srcc_pkg::ADDR_W-1:0]  r_len;
    logic [srcc_pkg::ADDR_W-1:0]  r_cursor;
    logic [srcc_pkg::REM_W-1:0]   r_remaining;
    logic [srcc_pkg::ADDR_W-1:0]  r_last;
    logic [srcc_pkg::ADDR_W-1:0]  r_span;
    logic [srcc_pkg::REM_W-1:0]   r_take;
    logic                         r_below;
    logic                         r_inside;
    logic                         r_res_valid;
    srcc_pkg::t_result            r_res;

    logic [srcc_pkg::CNT_W-1:0]   n_rd_idx;
    logic [srcc_pkg::REM_W-1:0]   n_take;
    srcc_pkg::t_region            n_wdata;

    function automatic logic [srcc_pkg::REM_W-1:0] to_pages(
        input logic [srcc_pkg::ADDR_W-1:0] n
    );
        to_pages = {1'b0, n[srcc_pkg::ADDR_W-1:srcc_pkg::PAGE_SHIFT]}
                 + srcc_pkg::REM_W'(|n[srcc_pkg::PAGE_SHIFT-1:0]);
    endfunction

    assign n_rd_idx = i_cmd.rd_prev ? (r_idx - srcc_pkg::CNT_W'(1)) : r_idx;
    assign n_take   = (to_pages(r_span) > r_remaining) ? r_remaining : to_pages(r_span);
    assign n_wdata  = i_cmd.wr_shift ? r_rd : srcc_pkg::t_region'({r_entry_start, r_entry_pages});

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_shift || i_cmd.wr_new) begin
            r_mem[r_idx[srcc_pkg::IDX_W-1:0]] <= n_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[n_rd_idx[srcc_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.finish;
            if (i_cmd.clear_count) begin
                r_count <= '0;
            end else if (i_cmd.wr_new) begin
                r_count <= r_count + srcc_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_entry_start <= i_item.entry_start;
            r_entry_pages <= i_item.entry_pages;
            r_len         <= i_item.range_length;
            r_cursor      <= i_item.range_start;
            r_idx         <= i_cmd.idx_from_count ? r_count : '0;
        end
        if (i_cmd.wr_shift) begin
            r_idx <= r_idx - srcc_pkg::CNT_W'(1);
        end
        if (i_cmd.idx_inc || i_cmd.q_upd) begin
            r_idx <= r_idx + srcc_pkg::CNT_W'(1);
        end
        if (i_cmd.q_init) begin
            r_remaining <= to_pages(r_len);
        end
        if (i_cmd.q_last) begin
            r_last  <= r_rd.base + {r_rd.pages, srcc_pkg::PAGE_SHIFT'(0)}
                     - srcc_pkg::ADDR_W'(1);
            r_below <= r_cursor < r_rd.base;
        end
        if (i_cmd.q_span) begin
            r_inside <= r_cursor <= r_last;
            r_span   <= r_last - r_cursor + srcc_pkg::ADDR_W'(1);
        end
        if (i_cmd.q_take) begin
            r_take <= n_take;
        end
        if (i_cmd.q_upd) begin
            r_remaining <= r_remaining - r_take;
            r_cursor    <= r_cursor
                         + {r_take[srcc_pkg::PAGES_W-1:0], srcc_pkg::PAGE_SHIFT'(0)};
        end
        if (i_cmd.finish) begin
            r_res.status       <= i_cmd.fin_status;
            r_res.stop_address <= i_cmd.fin_cursor ? r_cursor : '0;
        end
    end

    assign o_sts.full         = r_count >= srcc_pkg::CNT_W'(srcc_pkg::MAX_REGIONS);
    assign o_sts.idx_zero     = r_idx == '0;
    assign o_sts.idx_at_count = r_idx == r_count;
    assign o_sts.base_gt      = r_rd.base > r_entry_start;
    assign o_sts.len_zero     = r_len == '0;
    assign o_sts.rem_zero     = r_remaining == '0;
    assign o_sts.below        = r_below;
    assign o_sts.covered      = r_inside;

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= srcc_pkg::CNT_W'(srcc_pkg::MAX_REGIONS))
        else $error("region count beyond table depth");

    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_new |-> r_count < srcc_pkg::CNT_W'(srcc_pkg::MAX_REGIONS))
        else $error("insert into a full table");

    a_take_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.q_take |=> r_take <= r_remaining)
        else $error("page take exceeds remaining pages");

    a_rem_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.q_upd |=> r_remaining <= $past(r_remaining))
        else $error("remaining pages grew during walk");

endmodule

### hw/rtl/srcc_ctrl.sv
// controller state machine sequencing clear, sorted insert and coverage walk
// depends on srcc_pkg, drives srcc_dp through command and status structs
module srcc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [1:0]         i_command,
    input  logic               i_check_enabled,
    input  srcc_pkg::t_dp_sts  i_sts,
    output srcc_pkg::t_dp_cmd  o_cmd,
    output logic               busy
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_CHK = 4'd1;
    localparam logic [3:0] S_INS_CMP = 4'd2;
    localparam logic [3:0] S_Q_INIT  = 4'd3;
    localparam logic [3:0] S_Q_CHK   = 4'd4;
    localparam logic [3:0] S_Q_LAST  = 4'd5;
    localparam logic [3:0] S_Q_SPAN  = 4'd6;
    localparam logic [3:0] S_Q_TAKE  = 4'd7;
    localparam logic [3:0] S_Q_UPD   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch          = 1'b1;
                    o_cmd.idx_from_count = i_command == srcc_pkg::CMD_LOAD;
                    unique case (i_command)
                        srcc_pkg::CMD_CLEAR: begin
                            o_cmd.clear_count = 1'b1;
                            o_cmd.finish      = 1'b1;
                            o_cmd.fin_status  = srcc_pkg::ST_OK;
                        end
                        srcc_pkg::CMD_LOAD: begin
                            if (i_sts.full) begin
                                o_cmd.finish     = 1'b1;
                                o_cmd.fin_status = srcc_pkg::ST_FULL;
                            end else begin
                                n_state = S_INS_CHK;
                            end
                        end
                        srcc_pkg::CMD_QUERY: begin
                            n_state = S_Q_INIT;
                        end
                        default: begin
                            o_cmd.finish     = 1'b1;
                            o_cmd.fin_status = srcc_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_INS_CHK: begin
                if (i_sts.idx_zero) begin
                    o_cmd.wr_new     = 1'b1;
                    o_cmd.finish     = 1'b1;
                    o_cmd.fin_status = srcc_pkg::ST_OK;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_sts.base_gt) begin
                    o_cmd.wr_shift = 1'b1;
                    n_state        = S_INS_CHK;
                end else begin
                    o_cmd.wr_new     = 1'b1;
                    o_cmd.finish     = 1'b1;
                    o_cmd.fin_status = srcc_pkg::ST_OK;
                    n_state          = S_IDLE;
                end
            end
            S_Q_INIT: begin
                if (!i_check_enabled) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.fin_status = srcc_pkg::ST_OK;
                    o_cmd.fin_cursor = 1'b1;
                    n_state          = S_IDLE;
                end else if (i_sts.len_zero) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.fin_status = srcc_pkg::ST_INVALID;
                    o_cmd.fin_cursor = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.q_init = 1'b1;
                    n_state      = S_Q_CHK;
                end
            end
            S_Q_CHK: begin
                if (i_sts.idx_at_count || i_sts.rem_zero) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.fin_status = i_sts.rem_zero ? srcc_pkg::ST_OK
                                                      : srcc_pkg::ST_NOT_FOUND;
                    o_cmd.fin_cursor = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_Q_LAST;
                end
            end
            S_Q_LAST: begin
                o_cmd.q_last = 1'b1;
                n_state      = S_Q_SPAN;
            end
            S_Q_SPAN: begin
                if (i_sts.below) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.fin_status = srcc_pkg::ST_NOT_FOUND;
                    o_cmd.fin_cursor = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.q_span = 1'b1;
                    n_state      = S_Q_TAKE;
                end
            end
            S_Q_TAKE: begin
                if (i_sts.covered) begin
                    o_cmd.q_take = 1'b1;
                    n_state      = S_Q_UPD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_Q_CHK;
                end
            end
            S_Q_UPD: begin
                o_cmd.q_upd = 1'b1;
                n_state     = S_Q_CHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = r_state != S_IDLE;

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == S_IDLE)
        else $error("controller not idle after finishing a transaction");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch |-> r_state == S_IDLE)
        else $error("transaction latched while busy");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_new && o_cmd.wr_shift))
        else $error("two table writes in one cycle");

endmodule

### hw/rtl/sorted_region_coverage_check.sv
// Clear, an unused command and a load into a full table finish in the idle state;
// a load moves each larger entry up one place, then writes the new entry; a query
// that is disabled or has zero length finishes without reading the table, else it
// walks the table entries in order until covered, a gap, or the end of the table.
// One transaction at a time, the next accepted at the edge that takes the result;
// results are a one-cycle strobe, never stalled. Reset: table empty, check enabled.
module sorted_region_coverage_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  srcc_pkg::t_item                     i_item,
    output logic                                o_result_valid,
    output srcc_pkg::t_result                   o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srcc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [srcc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [srcc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic              r_check_enabled;
    srcc_pkg::t_dp_cmd w_cmd;
    srcc_pkg::t_dp_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_enabled <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && paddr == srcc_pkg::APB_ADDR_W'(4 * srcc_pkg::REG_CHECK_ENABLED)) begin
            r_check_enabled <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == srcc_pkg::APB_ADDR_W'(4 * srcc_pkg::REG_CHECK_ENABLED))
                  ? {{(srcc_pkg::APB_DATA_W-1){1'b0}}, r_check_enabled} : '0;

    srcc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_command       (i_item.command),
        .i_check_enabled (r_check_enabled),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd),
        .busy            (busy)
    );

    srcc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

### test/region_walk_checker.sv
// checker for the sorted region coverage check: watches the command, result and apb channels,
// predicts each result from its own copy of the region table and compares in order
// depends on srcc_pkg
module region_walk_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  srcc_pkg::t_item                 i_item,
    input  logic                            i_result_valid,
    input  srcc_pkg::t_result               i_result,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [srcc_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [srcc_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import srcc_pkg::*;

    logic [ADDR_W-1:0]  table_base [MAX_REGIONS];
    logic [PAGES_W-1:0] table_pages [MAX_REGIONS];
    int                 region_total;
    logic               check_on;
    t_result            due_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        region_total = 0;
        check_on     = 1'b1;
    end

    function automatic logic [ADDR_W-1:0] round_to_pages(input logic [ADDR_W-1:0] n);
        return (n >> PAGE_SHIFT) + ((n[PAGE_SHIFT-1:0] != '0) ? 64'd1 : 64'd0);
    endfunction

    function automatic logic [1:0] insert_region(input logic [ADDR_W-1:0] base,
                                                 input logic [PAGES_W-1:0] pages);
        int pos;
        int i;
        if (region_total >= MAX_REGIONS)
            return ST_FULL;
        pos = region_total;
        while (pos > 0 && table_base[pos-1] > base)
            pos--;
        for (i = region_total; i > pos; i--) begin
            table_base[i]  = table_base[i-1];
            table_pages[i] = table_pages[i-1];
        end
        table_base[pos]  = base;
        table_pages[pos] = pages;
        region_total++;
        return ST_OK;
    endfunction

    function automatic t_result walk_query(input logic [ADDR_W-1:0] first,
                                           input logic [ADDR_W-1:0] length);
        t_result           r;
        logic [ADDR_W-1:0] cursor;
        logic [ADDR_W-1:0] left;
        logic [ADDR_W-1:0] last;
        logic [ADDR_W-1:0] take;
        bit                gap;
        int                i;
        r.status       = ST_OK;
        r.stop_address = first;
        if (!check_on)
            return r;
        if (length == '0) begin
            r.status = ST_INVALID;
            return r;
        end
        cursor = first;
        left   = round_to_pages(length);
        gap    = 1'b0;
        for (i = 0; i < region_total && left != '0 && !gap; i++) begin
            if (cursor < table_base[i]) begin
                gap = 1'b1;
            end else begin
                last = table_base[i] - 64'd1 + {table_pages[i], 12'h000};
                if (cursor <= last) begin
                    take = round_to_pages(last - cursor + 64'd1);
                    if (take > left)
                        take = left;
                    left   = left - take;
                    cursor = cursor + (take << PAGE_SHIFT);
                end
            end
        end
        r.status       = (left != '0) ? ST_NOT_FOUND : ST_OK;
        r.stop_address = cursor;
        return r;
    endfunction

    function automatic t_result run_command(input t_item it);
        t_result r;
        r.status       = ST_OK;
        r.stop_address = '0;
        case (it.command)
            CMD_CLEAR: region_total = 0;
            CMD_LOAD:  r.status = insert_region(it.entry_start, it.entry_pages);
            CMD_QUERY: r = walk_query(it.range_start, it.range_length);
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            region_total = 0;
            check_on     = 1'b1;
            due_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == APB_ADDR_W'(4 * int'(REG_CHECK_ENABLED)))
                check_on = i_pwdata[0];
            if (i_result_valid) begin
                if (due_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result status %0d stop %h", $realtime,
                                 i_result.status, i_result.stop_address);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (want.status !== i_result.status
                            || want.stop_address !== i_result.stop_address) begin
                        if (o_fail_count < 10)
                            $display("%0t: result mismatch: expected status %0d stop %h, got status %0d stop %h",
                                     $realtime, want.status, want.stop_address,
                                     i_result.status, i_result.stop_address);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                due_results.push_back(run_command(i_item));
        end
        o_pending = due_results.size();
    end

endmodule

### test/testbench.sv
// top of the sorted region coverage check testbench: clock, reset, apb writes and
// command stimulus, with the verdict taken from region_walk_checker
// depends on srcc_pkg, sorted_region_coverage_check and region_walk_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import srcc_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int PHASES       = 8;
    localparam int TAIL_CYCLES  = 5 * MAX_REGIONS + 10;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    t_item                 item;
    logic                  result_valid;
    t_result               result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;
    int                    sent;

    always #10 clk = ~clk;

    sorted_region_coverage_check u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (item),
        .o_result_valid (result_valid),
        .o_result       (result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    region_walk_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (item),
        .i_result_valid (result_valid),
        .i_result       (result),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PAGES_W-1:0] rand_pages();
        return PAGES_W'({$urandom, $urandom});
    endfunction

    function automatic t_item make_item(input logic [1:0] cmd, input logic [ADDR_W-1:0] es,
                                        input logic [PAGES_W-1:0] ep,
                                        input logic [ADDR_W-1:0] rs,
                                        input logic [ADDR_W-1:0] rl);
        t_item it;
        it.command      = cmd;
        it.entry_start  = es;
        it.entry_pages  = ep;
        it.range_start  = rs;
        it.range_length = rl;
        return it;
    endfunction

    function automatic t_item noise_item();
        return make_item(2'($urandom_range(0, 3)), rand_addr(), rand_pages(), rand_addr(),
                         rand_addr());
    endfunction

    function automatic t_item load_item(input logic [ADDR_W-1:0] base,
                                        input logic [PAGES_W-1:0] pages);
        return make_item(CMD_LOAD, base, pages, rand_addr(), rand_addr());
    endfunction

    function automatic t_item query_item(input logic [ADDR_W-1:0] first,
                                         input logic [ADDR_W-1:0] length);
        return make_item(CMD_QUERY, rand_addr(), rand_pages(), first, length);
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction is accepted
    task automatic send(input t_item it);
        while (!(sent >= 700 && sent < 1000) && $urandom_range(99) < 6) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
    endtask

    task automatic cfg_write(input int idx, input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= {31'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // lay out a run of mostly adjacent regions, load them out of order, then query into it
    task automatic load_and_probe(input bit fill);
        logic [ADDR_W-1:0]  lay_base [72];
        logic [PAGES_W-1:0] lay_pages [72];
        int                 order [72];
        int                 n;
        int                 k;
        int                 j;
        int                 tmp;
        int                 pick;
        int                 nq;
        logic [ADDR_W-1:0]  origin;
        logic [ADDR_W-1:0]  cursor;
        logic [ADDR_W-1:0]  qstart;
        logic [ADDR_W-1:0]  qlen;
        if (fill || $urandom_range(9) < 8)
            send(make_item(CMD_CLEAR, rand_addr(), rand_pages(), rand_addr(), rand_addr()));
        if (fill)
            n = MAX_REGIONS + $urandom_range(1, 3);
        else if ($urandom_range(9) == 0)
            n = $urandom_range(9, MAX_REGIONS);
        else
            n = $urandom_range(1, 8);
        case ($urandom_range(3))
            1: origin = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 65535));
            2: origin = 64'($urandom_range(0, 65535));
            default: origin = rand_addr();
        endcase
        if ($urandom_range(3) != 0)
            origin[PAGE_SHIFT-1:0] = '0;
        cursor = origin;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 65 || k == 0)
                lay_base[k] = cursor;
            else if (pick < 82)
                lay_base[k] = cursor + 64'($urandom_range(1, 9000));
            else if (pick < 92)
                lay_base[k] = cursor - (64'($urandom_range(0, 3)) << PAGE_SHIFT);
            else
                lay_base[k] = lay_base[k-1];
            lay_pages[k] = ($urandom_range(49) == 0) ? rand_pages()
                                                     : PAGES_W'($urandom_range(0, 6));
            cursor   = lay_base[k] + {lay_pages[k], 12'h000};
            order[k] = k;
        end
        if ($urandom_range(4) == 0) begin
            for (k = 0; k < n; k++)
                order[k] = n - 1 - k;
        end else begin
            for (k = n - 1; k > 0; k--) begin
                j        = $urandom_range(k);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
        end
        for (k = 0; k < n; k++) begin
            send(load_item(lay_base[order[k]], lay_pages[order[k]]));
            if ($urandom_range(39) == 0)
                send(noise_item());
        end
        nq = $urandom_range(3, 10);
        for (k = 0; k < nq; k++) begin
            j      = $urandom_range(n - 1);
            qstart = lay_base[j];
            if ($urandom_range(3) == 0)
                qstart = qstart + 64'($urandom_range(0, 12287));
            else if ($urandom_range(7) == 0)
                qstart = qstart - 64'($urandom_range(1, 4096));
            pick = $urandom_range(99);
            if (pick < 5)
                qlen = '0;
            else if (pick < 10)
                qlen = rand_addr();
            else if (pick < 55)
                qlen = cursor - qstart + 64'($urandom_range(0, 8191)) - 64'd4096;
            else
                qlen = 64'($urandom_range(1, 40000));
            send(query_item(qstart, qlen));
            if ($urandom_range(9) == 0)
                send(noise_item());
        end
    endtask

    initial begin
        int  phase;
        int  base_items;
        bit  first;
        rst_n   = 1'b0;
        start   = 1'b0;
        item    = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        sent    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        cfg_write(int'(REG_CHECK_ENABLED), 1'b1);
        send(query_item(64'h1000, 64'd1));
        send(query_item(64'h1234, 64'd0));
        send(make_item(2'd3, '1, '1, '1, '1));
        send(load_item(64'h1000, 52'd2));
        send(load_item(64'h3000, 52'd1));
        send(load_item(64'h1000, 52'd1));
        send(load_item(64'h5000, 52'd0));
        send(load_item(64'h0800, 52'd1));
        send(query_item(64'h1000, 64'h3000));
        send(query_item(64'h1800, 64'h2801));
        send(query_item(64'h0, 64'd1));
        send(query_item(64'h1000, '1));
        send(query_item(64'h4000, 64'd1));
        send(load_item(64'hFFFF_FFFF_FFFF_F000, 52'd3));
        send(query_item(64'hFFFF_FFFF_FFFF_F000, 64'h3000));
        send(load_item('1, '1));
        send(query_item('1, '1));
        send(make_item(CMD_CLEAR, '1, '1, '1, '1));
        send(query_item(64'h1000, 64'h1000));
        drain();
        cfg_write(int'(REG_CHECK_ENABLED), 1'b0);
        send(query_item(64'h10, 64'd0));
        send(query_item('1, '1));
        send(load_item(64'h0, 52'd0));
        send(query_item(64'h0, 64'h1000));

        base_items = sent;
        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            cfg_write(int'(REG_CHECK_ENABLED), (phase == 2 || phase == 5) ? 1'b0 : 1'b1);
            first = 1'b1;
            while (sent < base_items + (phase + 1) * RANDOM_ITEMS / PHASES) begin
                load_and_probe(first && (phase == 0 || phase == 4));
                first = 1'b0;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
